// ===== hw/rtl/blec_pkg.sv =====
// Package for the bright line edge classifier.
// Holds pixel and class types, field widths, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package blec_pkg;

  // parameter defaults
  localparam int MAX_DIST_DEF = 15;
  localparam int MAX_COLS_DEF = 4096;

  // field widths
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int XD_W    = 4;
  localparam int DELTA_W = 8;
  localparam int CFG_W   = 8;
  // results per item: one due pixel plus up to x_distance flushed pixels
  localparam int CNT_W   = XD_W + 1;

  // register reset values
  localparam logic [XD_W-1:0]    X_DIST_RST    = 4'd5;
  localparam logic [DELTA_W-1:0] MIN_DELTA_RST = 8'd20;

  // register indexes
  typedef enum logic [0:0] {
    REG_X_DIST    = 1'b0,
    REG_MIN_DELTA = 1'b1
  } reg_idx_t;

  // pixel classes
  typedef enum logic [1:0] {
    CLS_NONE    = 2'd0,
    CLS_LEFT    = 2'd1,
    CLS_BETWEEN = 2'd2,
    CLS_RIGHT   = 2'd3
  } cls_t;

  // one pixel, first channel in the lowest bits
  typedef struct packed {
    logic [CHAN_W-1:0] chan_c;
    logic [CHAN_W-1:0] chan_b;
    logic [CHAN_W-1:0] chan_a;
  } pix_t;

  // control of an item held between the window stage and the emitter
  typedef struct packed {
    logic             valid;
    logic             row_end;
    logic             main_ok;   // a pixel is due for classification
    logic             pair_ok;   // both neighbours of the due pixel are in the row
    logic [CNT_W-1:0] flush_cnt; // pending pixels flushed at row end
  } item_ctl_t;

endpackage

// ===== hw/rtl/blec_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module blec_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and register both reads when enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hw/rtl/blec_front.sv =====
// Window stage: column counter, pixel window RAM and the item register.
// Depends on blec_pkg and blec_ram.
`timescale 1ns / 1ps

module blec_front
  import blec_pkg::*;
#(
  parameter int MAX_DIST = MAX_DIST_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [XD_W-1:0] x_dist,
  input  logic            in_valid,
  output logic            in_ready,
  input  pix_t            in_pix,
  input  logic            in_end,
  input  logic            take,
  output item_ctl_t       item,
  output pix_t            item_pix,
  output pix_t            item_mid,
  output pix_t            item_left
);

  localparam int DEPTH = 2 * MAX_DIST + 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int AW    = PTR_W + 1;
  localparam int COL_W = $clog2(MAX_COLS);

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  item_ctl_t        item_r, item_nxt;
  pix_t             pix_r;
  logic             accept;
  logic [AW-1:0]    diff_mid, diff_left;
  logic [PTR_W-1:0] addr_mid, addr_left;
  logic [31:0]      col_w, dist_w;
  logic [CNT_W-1:0] flush;
  logic [PIX_W-1:0] rd_mid, rd_left;

  assign in_ready = !item_r.valid || take;
  assign accept   = in_valid && in_ready;

  // read addresses of the due pixel and of its left neighbour
  always_comb begin
    diff_mid  = {1'b0, wr_ptr_r} - AW'(x_dist);
    diff_left = {1'b0, wr_ptr_r} - AW'({x_dist, 1'b0});
    addr_mid  = diff_mid[AW-1]  ? PTR_W'(diff_mid  + AW'(DEPTH)) : diff_mid[PTR_W-1:0];
    addr_left = diff_left[AW-1] ? PTR_W'(diff_left + AW'(DEPTH)) : diff_left[PTR_W-1:0];
  end

  // position flags of the incoming pixel
  always_comb begin
    col_w  = 32'(col_r);
    dist_w = 32'(x_dist);
    if (in_end && x_dist != '0) begin
      flush = (col_w < dist_w - 32'd1) ? CNT_W'(col_w + 32'd1) : CNT_W'(x_dist);
    end else begin
      flush = '0;
    end
    item_nxt.valid     = accept || (item_r.valid && !take);
    item_nxt.row_end   = in_end;
    item_nxt.main_ok   = col_w >= dist_w;
    item_nxt.pair_ok   = (x_dist != '0) && (col_w >= 2 * dist_w);
    item_nxt.flush_cnt = flush;
    if (!accept) begin
      item_nxt.row_end   = item_r.row_end;
      item_nxt.main_ok   = item_r.main_ok;
      item_nxt.pair_ok   = item_r.pair_ok;
      item_nxt.flush_cnt = item_r.flush_cnt;
    end
  end

  // advance column and write pointer per transfer
  always_comb begin
    col_nxt    = col_r;
    wr_ptr_nxt = wr_ptr_r;
    if (accept) begin
      if (in_end) begin
        col_nxt = '0;
      end else if (col_w < MAX_COLS - 1) begin
        col_nxt = col_r + COL_W'(1);
      end
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      col_r        <= '0;
      item_r.valid <= 1'b0;
    end else begin
      wr_ptr_r     <= wr_ptr_nxt;
      col_r        <= col_nxt;
      item_r.valid <= item_nxt.valid;
    end
    // hold item payload until taken
    item_r.row_end   <= item_nxt.row_end;
    item_r.main_ok   <= item_nxt.main_ok;
    item_r.pair_ok   <= item_nxt.pair_ok;
    item_r.flush_cnt <= item_nxt.flush_cnt;
  end

  // hold the incoming pixel as the right neighbour
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= in_pix;
    end
  end

  blec_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk     (clk),
    .we      (accept),
    .waddr   (wr_ptr_r),
    .wdata   (in_pix),
    .re      (accept),
    .raddr_a (addr_mid),
    .raddr_b (addr_left),
    .rdata_a (rd_mid),
    .rdata_b (rd_left)
  );

  assign item      = item_r;
  assign item_pix  = pix_r;
  assign item_mid  = pix_t'(rd_mid);
  assign item_left = pix_t'(rd_left);

endmodule

// ===== hw/rtl/blec_emit.sv =====
// Classifier and emitter: brightness test, run tracking, result sequencing
// and the output register. Depends on blec_pkg.
`timescale 1ns / 1ps

module blec_emit
  import blec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [DELTA_W-1:0] delta,
  input  item_ctl_t          item,
  input  pix_t               item_pix,
  input  pix_t               item_mid,
  input  pix_t               item_left,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output cls_t               out_cls,
  output logic               out_last
);

  logic [CNT_W-1:0] cnt_r;
  cls_t             cls0_r, cls1_r;
  logic             end_r;
  logic             run_r;
  logic             out_valid_r;
  cls_t             out_cls_r;
  logic             out_last_r;

  logic             bright, run_main, run_nxt, emit, free;
  cls_t             cls_main, cls_flush, cls_x, cls_y;
  logic [CNT_W-1:0] n_total;

  // every channel of p beats q by more than delta, without wrap
  function automatic logic exceeds(input pix_t p, input pix_t q,
                                   input logic [DELTA_W-1:0] dl);
    logic [PIX_W-1:0] pv, qv;
    logic             ok;
    pv = p;
    qv = q;
    ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if ({1'b0, pv[i*CHAN_W +: CHAN_W]} <=
          {1'b0, qv[i*CHAN_W +: CHAN_W]} + {1'b0, dl}) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // classify the due pixel and work out the result sequence
  always_comb begin
    bright    = item.pair_ok && exceeds(item_mid, item_left, delta) &&
                exceeds(item_mid, item_pix, delta);
    cls_main  = bright ? (run_r ? CLS_BETWEEN : CLS_LEFT)
                       : (run_r ? CLS_RIGHT : CLS_NONE);
    run_main  = item.main_ok ? bright : run_r;
    cls_flush = run_main ? CLS_RIGHT : CLS_NONE;
    run_nxt   = item.row_end ? 1'b0 : run_main;
    cls_x     = item.main_ok ? cls_main : cls_flush;
    cls_y     = item.main_ok ? cls_flush : CLS_NONE;
    n_total   = CNT_W'(item.main_ok) + item.flush_cnt;
  end

  // handshake between item register, emitter and output register
  assign emit = (cnt_r != '0) && (!out_valid_r || out_ready);
  assign free = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && emit);
  assign take = item.valid && ((n_total == '0) || free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // load a new item, or step through the pending results
      if (take && n_total != '0) begin
        cnt_r <= n_total;
      end else if (emit) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (take) begin
        run_r <= run_nxt;
      end
      // hold a result until its transfer
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && n_total != '0) begin
      cls0_r <= cls_x;
      cls1_r <= cls_y;
      end_r  <= item.row_end;
    end else if (emit) begin
      cls0_r <= cls1_r;
      cls1_r <= CLS_NONE;
    end
    if (emit) begin
      out_cls_r  <= cls0_r;
      out_last_r <= end_r && (cnt_r == CNT_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_cls   = out_cls_r;
  assign out_last  = out_last_r;

endmodule

// ===== hw/rtl/bright_line_edge_classifier.sv =====
// Top level of the bright line edge classifier: configuration registers
// and the two pipeline parts. Depends on blec_pkg, blec_front and blec_emit.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in_     | slave     | in_tvalid / in_tready   | in_tdata pixel, in_tlast row end
//  out_    | master    | out_tvalid / out_tready | out_tdata class, out_tlast row last
//  cfg_    | write     | cfg_we                  | cfg_index, cfg_wdata
//
// One pixel per clock is accepted. A result passes the item, result and output
// registers after its completing pixel; the due pixel is x_distance columns
// behind. At row end the emitter sends up to x_distance + 1 results, one per
// cycle, and holds the next item meanwhile. A stalled output holds the result
// register and backs up through the emitter and the item register to in_tready.
// Reset clears column, run and valid state; the pixel window needs no clearing.
`timescale 1ns / 1ps

module bright_line_edge_classifier
  import blec_pkg::*;
#(
  parameter int MAX_DIST = MAX_DIST_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,   // chan_a [7:0], chan_b [15:8], chan_c [23:16]
  input  logic             in_tlast,   // row_end
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // pixel_class [1:0], zero [7:2]
  output logic             out_tlast,  // row_last
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic [XD_W-1:0]    x_dist_r;
  logic [DELTA_W-1:0] min_delta_r;
  logic [XD_W-1:0]    x_dist;
  item_ctl_t          item;
  pix_t               item_pix, item_mid, item_left;
  logic               take;
  cls_t               out_cls;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_dist_r    <= X_DIST_RST;
      min_delta_r <= MIN_DELTA_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_X_DIST:    x_dist_r    <= cfg_wdata[XD_W-1:0];
        REG_MIN_DELTA: min_delta_r <= cfg_wdata[DELTA_W-1:0];
        default:       ;
      endcase
    end
  end

  // limit the distance to the window size
  assign x_dist = (32'(x_dist_r) > MAX_DIST) ? XD_W'(MAX_DIST) : x_dist_r;

  blec_front #(
    .MAX_DIST (MAX_DIST),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .x_dist    (x_dist),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pix    (pix_t'(in_tdata)),
    .in_end    (in_tlast),
    .take      (take),
    .item      (item),
    .item_pix  (item_pix),
    .item_mid  (item_mid),
    .item_left (item_left)
  );

  blec_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .delta     (min_delta_r),
    .item      (item),
    .item_pix  (item_pix),
    .item_mid  (item_mid),
    .item_left (item_left),
    .take      (take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cls   (out_cls),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'd0, out_cls};

endmodule
